FILE: sv/utf8sd_pkg.sv
// utf8sd_pkg: shared types, constants and the byte classifier of the UTF-8 stream decoder.
// Used by utf8sd_front, utf8sd_back and utf8_stream_decoder_top. No dependencies.
package utf8sd_pkg;

  localparam int unsigned CP_W   = 21;  // code point width
  localparam int unsigned USED_W = 3;   // bytes_used width
  localparam int unsigned BUF_N  = 4;   // held bytes plus the incoming one

  // Byte class, resolved once at the front
  typedef enum logic [2:0] {
    CLS_BAD   = 3'd0,
    CLS_ASCII = 3'd1,
    CLS_LEAD2 = 3'd2,
    CLS_LEAD3 = 3'd3,
    CLS_LEAD4 = 3'd4,
    CLS_CONT  = 3'd5
  } byte_cls_t;

  typedef struct packed {
    logic [7:0] data;
    byte_cls_t  cls;
  } cls_byte_t;

  typedef struct packed {
    cls_byte_t cb;
    logic      last;
  } q_entry_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic     vld;
    q_entry_t entry;
  } q_head_t;

  function automatic byte_cls_t classify(input logic [7:0] b);
    byte_cls_t c;
    priority if (b[7] == 1'b0)          c = CLS_ASCII;
    else if (b[7:6] == 2'b10)           c = CLS_CONT;
    else if (b[7:5] == 3'b110)          c = CLS_LEAD2;
    else if (b[7:4] == 4'b1110)         c = CLS_LEAD3;
    else if (b[7:3] == 5'b11110)        c = CLS_LEAD4;
    else                                c = CLS_BAD;
    return c;
  endfunction

endpackage

FILE: sv/utf8sd_front.sv
// utf8sd_front: input side. Classifies each accepted word and queues it for the back end.
// Depends on utf8sd_pkg.
module utf8sd_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output utf8sd_pkg::q_head_t head,
  input  logic                pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  utf8sd_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;

  assign in_ready = (count_r != CNT_W'(DEPTH));
  assign push     = in_valid && in_ready;

  assign head.vld   = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].cb.data <= in_byte;
      mem_r[wr_ptr_r].cb.cls  <= utf8sd_pkg::classify(in_byte);
      mem_r[wr_ptr_r].last    <= in_last;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("pointers disagree with empty count");

endmodule

FILE: sv/utf8sd_back.sv
// utf8sd_back: decode engine. Holds the open sequence, emits one result per cycle
// into an output register while that register is free. Depends on utf8sd_pkg.
module utf8sd_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  utf8sd_pkg::q_head_t                 head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [utf8sd_pkg::CP_W-1:0]         out_code_point,
  output logic                                out_is_invalid,
  output logic [utf8sd_pkg::USED_W-1:0]       out_bytes_used,
  output logic                                out_last
);

  localparam int unsigned CP_W   = utf8sd_pkg::CP_W;
  localparam int unsigned USED_W = utf8sd_pkg::USED_W;
  localparam int unsigned BUF_N  = utf8sd_pkg::BUF_N;

  utf8sd_pkg::cls_byte_t buf_r [BUF_N];
  utf8sd_pkg::cls_byte_t buf_nxt [BUF_N];
  logic [2:0] n_r, n_nxt;
  logic       active_r, active_nxt;
  logic       last_r, last_nxt;

  // working view: held bytes, plus the queue head when starting a new word
  utf8sd_pkg::cls_byte_t v_buf [BUF_N];
  logic [2:0]            v_n;
  logic                  v_last;
  logic                  v_ok;

  logic [2:0]        len;
  logic              cbad, short_seq, bad, wait_more;
  logic [2:0]        used;
  logic [2:0]        n_after;
  logic [CP_W-1:0]   cp;
  logic              out_free, fire, emit;

  logic              out_valid_r;
  logic [CP_W-1:0]   out_cp_r;
  logic              out_inv_r;
  logic [USED_W-1:0] out_used_r;
  logic              out_last_r;

  always_comb begin
    for (int i = 0; i < BUF_N; i++) v_buf[i] = buf_r[i];
    if (active_r) begin
      v_n    = n_r;
      v_last = last_r;
      v_ok   = 1'b1;
    end else begin
      v_buf[n_r[1:0]] = head.entry.cb;
      v_n    = n_r + 3'd1;
      v_last = head.entry.last;
      v_ok   = head.vld;
    end
  end

  // decision on the oldest byte
  always_comb begin
    unique case (v_buf[0].cls)
      utf8sd_pkg::CLS_ASCII: len = 3'd1;
      utf8sd_pkg::CLS_LEAD2: len = 3'd2;
      utf8sd_pkg::CLS_LEAD3: len = 3'd3;
      utf8sd_pkg::CLS_LEAD4: len = 3'd4;
      default:               len = 3'd0;
    endcase
    cbad = 1'b0;
    for (int i = 1; i < BUF_N; i++) begin
      if (3'(i) < len && 3'(i) < v_n && v_buf[i].cls != utf8sd_pkg::CLS_CONT) cbad = 1'b1;
    end
    short_seq = (v_n < len);
    bad       = (len == 3'd0) || cbad || (short_seq && v_last);
    wait_more = !bad && short_seq;
    used      = bad ? 3'd1 : len;
    n_after   = v_n - used;

    unique case (len)
      3'd1:    cp = {13'd0, v_buf[0].data};
      3'd2:    cp = {10'd0, v_buf[0].data[4:0], v_buf[1].data[5:0]};
      3'd3:    cp = {5'd0, v_buf[0].data[3:0], v_buf[1].data[5:0], v_buf[2].data[5:0]};
      3'd4:    cp = {v_buf[0].data[2:0], v_buf[1].data[5:0], v_buf[2].data[5:0],
                     v_buf[3].data[5:0]};
      default: cp = '0;
    endcase
    if (bad) cp = '0;
  end

  assign out_free = !out_valid_r || out_ready;
  assign fire     = v_ok && (wait_more || out_free);
  assign emit     = fire && !wait_more;
  assign pop      = fire && !active_r;

  always_comb begin
    for (int i = 0; i < BUF_N; i++) buf_nxt[i] = buf_r[i];
    n_nxt      = n_r;
    active_nxt = active_r;
    last_nxt   = last_r;
    if (fire) begin
      last_nxt = v_last;
      if (wait_more) begin
        for (int i = 0; i < BUF_N; i++) buf_nxt[i] = v_buf[i];
        n_nxt      = v_n;
        active_nxt = 1'b0;
      end else begin
        unique case (used)
          3'd1: begin
            buf_nxt[0] = v_buf[1];
            buf_nxt[1] = v_buf[2];
            buf_nxt[2] = v_buf[3];
            buf_nxt[3] = v_buf[3];
          end
          3'd2: begin
            buf_nxt[0] = v_buf[2];
            buf_nxt[1] = v_buf[3];
            buf_nxt[2] = v_buf[2];
            buf_nxt[3] = v_buf[3];
          end
          3'd3: begin
            buf_nxt[0] = v_buf[3];
            buf_nxt[1] = v_buf[1];
            buf_nxt[2] = v_buf[2];
            buf_nxt[3] = v_buf[3];
          end
          default: begin
            for (int i = 0; i < BUF_N; i++) buf_nxt[i] = v_buf[i];
          end
        endcase
        n_nxt      = n_after;
        active_nxt = (n_after != 3'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      active_r    <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      n_r      <= n_nxt;
      active_r <= active_nxt;
      last_r   <= last_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BUF_N; i++) buf_r[i] <= buf_nxt[i];
    if (emit) begin
      out_cp_r   <= cp;
      out_inv_r  <= bad;
      out_used_r <= used;
      out_last_r <= v_last && (n_after == 3'd0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;
  assign out_is_invalid = out_inv_r;
  assign out_bytes_used = out_used_r;
  assign out_last       = out_last_r;

  a_idle_holds_three: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> n_r <= 3'd3)
    else $error("more than three bytes held between words");
  a_invalid_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inv_r) |-> (out_used_r == 3'd1 && out_cp_r == '0))
    else $error("invalid result with nonzero payload");
  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && v_last && n_after == 3'd0) |=> (n_r == 3'd0 && !active_r))
    else $error("bytes left over after end of string");
  a_no_wait_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (v_ok && v_last) |-> !wait_more)
    else $error("prefix held across end of string");

endmodule

FILE: sv/utf8_stream_decoder_top.sv
// utf8_stream_decoder_top: UTF-8 stream decoder, front queue plus decode back end.
// Depends on utf8sd_pkg, utf8sd_front and utf8sd_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one word per handshake, in_byte is one
//   raw byte of the string, in_last flags its final byte.
//   Result channel (out_valid/out_ready): one decoded code point per word, with
//   out_is_invalid, out_bytes_used and out_last (set on the final result of a
//   string). A byte that starts no valid sequence gives an invalid result that
//   consumes that byte alone; the bytes held behind it are rescanned.
//   Path: an ASCII byte is written into the queue at the accepting edge and
//   then into the output register, which drives the result port.
//   Throughput: one byte per cycle on well-formed text while out_ready is high.
//   The back end emits at most one result per cycle, so a byte that resolves
//   into k results (invalid runs, end of string with a short sequence) occupies
//   it for k cycles, plus one cycle when a rescan ends on a prefix that must wait
//   for more bytes. The input queue of QUEUE_DEPTH words absorbs these bursts.
//   Reset: synchronous, active low; empties the queue, drops held bytes and
//   any pending result. No clearing pass is needed.
//   Stall: while out_ready is low the result stays put; the back end stops,
//   the queue fills, then in_ready drops.
module utf8_stream_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_byte,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [utf8sd_pkg::CP_W-1:0]        out_code_point,
  output logic                               out_is_invalid,
  output logic [utf8sd_pkg::USED_W-1:0]      out_bytes_used,
  output logic                               out_last
);

  utf8sd_pkg::q_head_t head;  // classified word at the queue head
  logic                pop;   // back end takes the head word

  utf8sd_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .head     (head),
    .pop      (pop)
  );

  utf8sd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_is_invalid (out_is_invalid),
    .out_bytes_used (out_bytes_used),
    .out_last       (out_last)
  );

  // a result never carries more bytes than a sequence can hold
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bytes_used >= 3'd1 && out_bytes_used <= 3'd4))
    else $error("bytes_used out of range");
  // invalid flag and decoded value are exclusive
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_invalid) |-> out_code_point == '0)
    else $error("invalid result carries a code point");
  // single-byte valid result is plain ASCII
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_invalid && out_bytes_used == 3'd1) |-> out_code_point < 21'd128)
    else $error("one-byte result above ASCII range");

endmodule

FILE: tb/sv/utf8_stream_decoder_top_test.sv
`timescale 1ns / 1ps
// utf8_stream_decoder_top_test: self-checking testbench for the UTF-8 stream decoder.
// Depends on utf8sd_pkg and utf8_stream_decoder_top; predicts each decoded word locally.
module utf8_stream_decoder_top_test;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned QUIET_LIMIT  = 1000; // cycles with no word moving on either side
  localparam int unsigned HOLD_CYCLES  = 80;   // long receiver hold-off for the fill-up test
  localparam int unsigned DRAIN_CYCLES = 12;   // settling wait after the expected results are in
  localparam int unsigned PHASE_WORDS  = 36;   // minimum random bytes per idling phase

  // One expected result word
  typedef struct {
    logic [utf8sd_pkg::CP_W-1:0]   cp;
    logic                          bad;
    logic [utf8sd_pkg::USED_W-1:0] used;
    logic                          fin;
  } decoded_cp_t;

  // Ways a random string gets broken
  typedef enum int unsigned {
    FLAW_RAW_BYTE,   // any byte value at all
    FLAW_CUT_SHORT,  // lead with fewer continuations than it announces
    FLAW_BAD_CONT    // one continuation replaced by a non-continuation byte
  } flaw_kind_t;

  logic                            clk      = 1'b0;
  logic                            rst_n    = 1'b0;
  logic                            in_valid = 1'b0;
  logic [7:0]                      in_byte  = 8'h00;
  logic                            in_last  = 1'b0;
  logic                            out_ready = 1'b0;
  logic                            in_ready;
  logic                            out_valid;
  logic [utf8sd_pkg::CP_W-1:0]     out_code_point;
  logic                            out_is_invalid;
  logic [utf8sd_pkg::USED_W-1:0]   out_bytes_used;
  logic                            out_last;

  // Local copy of the decoder state
  logic [7:0]          held_seq [3];
  int unsigned         held_len = 0;
  decoded_cp_t         cp_expect_q [$];

  // Bytes of the string being built for sending
  logic [7:0]          str_bytes [$];

  int unsigned         idle_pct  = 0;  // sender idles in this share of cycles
  int unsigned         stall_pct = 0;  // receiver stalls in this share of cycles
  int unsigned         hold_seq  = 0;  // bumped by the test to request a hold-off
  int unsigned         hold_seen = 0;
  int unsigned         hold_left = 0;
  int unsigned         quiet_cycles  = 0;
  int unsigned         error_count   = 0;
  int unsigned         words_sent    = 0;
  int unsigned         results_seen  = 0;
  int unsigned         invalid_seen  = 0;
  int unsigned         strings_sent  = 0;

  utf8_stream_decoder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_is_invalid (out_is_invalid),
    .out_bytes_used (out_bytes_used),
    .out_last       (out_last)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction. Held bytes plus the new one are scanned from the front:
  // a good sequence gives one code point, a bad lead / bad continuation /
  // sequence cut by end of string gives one invalid word consuming the lead
  // only, and the rest is rescanned. A valid but short prefix waits unless
  // the byte closes the string, in which case everything is flushed and the
  // final word of the step carries the end flag.
  // ---------------------------------------------------------------------------
  function automatic void predict_word(input logic [7:0] b, input logic fin);
    logic [7:0]                  seq [4];
    int unsigned                 n, len, used, have, i, made;
    logic                        bad;
    logic [utf8sd_pkg::CP_W-1:0] cp;
    utf8sd_pkg::byte_cls_t       cls;
    decoded_cp_t                 res;
    for (i = 0; i < held_len; i++) seq[i] = held_seq[i];
    seq[held_len] = b;
    n = held_len + 1;
    made = 0;
    while (n > 0) begin
      casez (seq[0])
        8'b0???????: cls = utf8sd_pkg::CLS_ASCII;
        8'b10??????: cls = utf8sd_pkg::CLS_CONT;
        8'b110?????: cls = utf8sd_pkg::CLS_LEAD2;
        8'b1110????: cls = utf8sd_pkg::CLS_LEAD3;
        8'b11110???: cls = utf8sd_pkg::CLS_LEAD4;
        default:     cls = utf8sd_pkg::CLS_BAD;
      endcase
      case (cls)
        utf8sd_pkg::CLS_ASCII: len = 1;
        utf8sd_pkg::CLS_LEAD2: len = 2;
        utf8sd_pkg::CLS_LEAD3: len = 3;
        utf8sd_pkg::CLS_LEAD4: len = 4;
        default:               len = 0;
      endcase
      bad  = 1'b0;
      used = 0;
      cp   = '0;
      if (len == 0) begin
        bad = 1'b1;
      end else if (len == 1) begin
        cp[7:0] = seq[0];
        used = 1;
      end else begin
        have = (n < len) ? n : len;
        for (i = 1; i < have; i++) begin
          if (seq[i][7:6] != 2'b10) bad = 1'b1;
        end
        if (!bad && n < len) begin
          if (fin) bad = 1'b1;
          else break;  // prefix waits for more bytes
        end
        if (!bad) begin
          cp[7:0] = seq[0] & (8'hFF >> (len + 1));
          for (i = 1; i < len; i++) cp = {cp[utf8sd_pkg::CP_W-7:0], seq[i][5:0]};
          used = len;
        end
      end
      if (bad) begin
        used = 1;
        cp   = '0;
      end
      res.cp   = cp;
      res.bad  = bad;
      res.used = used[utf8sd_pkg::USED_W-1:0];
      res.fin  = 1'b0;
      cp_expect_q.push_back(res);
      made++;
      for (i = used; i < n; i++) seq[i - used] = seq[i];
      n -= used;
    end
    if (fin) begin
      if (made > 0) begin
        res = cp_expect_q.pop_back();
        res.fin = 1'b1;
        cp_expect_q.push_back(res);
      end
      n = 0;
    end
    for (i = 0; i < n; i++) held_seq[i] = seq[i];
    held_len = n;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Offers one word, idling first at the phase's rate. Valid is held
  // with a steady payload until in_ready is seen at a rising edge; the word
  // is then fed to the predictor in that same step.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input logic fin);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    do @(posedge clk); while (!in_ready);
    predict_word(b, fin);
    words_sent++;
  endtask

  // Send the built string, end marker on its final byte
  task automatic send_text();
    int i;
    for (i = 0; i < str_bytes.size(); i++) send_word(str_bytes[i], i == str_bytes.size() - 1);
    str_bytes.delete();
    strings_sent++;
  endtask

  // Append one well-formed character of len bytes with random payload bits
  function automatic void append_char(input int unsigned len);
    logic [31:0] r;
    logic [7:0]  lead;
    int unsigned i;
    r = $urandom;
    case (len)
      1:       lead = {1'b0, r[6:0]};
      2:       lead = {3'b110, r[4:0]};
      3:       lead = {4'b1110, r[3:0]};
      default: lead = {5'b11110, r[2:0]};
    endcase
    str_bytes.push_back(lead);
    for (i = 1; i < len; i++) begin
      r = $urandom;
      str_bytes.push_back({2'b10, r[5:0]});
    end
  endfunction

  function automatic void append_flaw();
    logic [31:0] r;
    int unsigned len, idx;
    flaw_kind_t  kind;
    r    = $urandom;
    kind = flaw_kind_t'($urandom_range(2));
    len  = $urandom_range(4, 2);
    case (kind)
      FLAW_RAW_BYTE: str_bytes.push_back(r[7:0]);
      FLAW_CUT_SHORT: begin
        append_char(len);
        repeat ($urandom_range(len - 1, 1)) void'(str_bytes.pop_back());
      end
      default: begin
        append_char(len);
        idx = str_bytes.size() - $urandom_range(len - 1, 1);
        str_bytes[idx] = {r[7] ? 2'b11 : 2'b00, r[5:0]};  // top bits never 10
      end
    endcase
  endfunction

  // Random string of 1..chars characters, each broken with odds flaw_pct
  function automatic void build_string(input int unsigned chars, input int unsigned flaw_pct);
    int unsigned i, count;
    count = $urandom_range(chars, 1);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < flaw_pct) append_flaw();
      else append_char($urandom_range(4, 1));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver. Stalls at the phase's rate; a hold-off request from the test
  // keeps out_ready low until the HOLD_CYCLES countdown kept here runs out.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
    error_count++;
  endtask

  // Each accepted result word against the oldest prediction
  always @(posedge clk) begin : check_results
    decoded_cp_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_is_invalid === 1'b1) invalid_seen++;
      if (cp_expect_q.size() == 0) begin
        note_mismatch("unexpected word, code_point", 0, out_code_point);
      end else begin
        want = cp_expect_q.pop_front();
        if (out_code_point !== want.cp)   note_mismatch("code_point", want.cp, out_code_point);
        if (out_is_invalid !== want.bad)  note_mismatch("is_invalid", want.bad, out_is_invalid);
        if (out_bytes_used !== want.used) note_mismatch("bytes_used", want.used, out_bytes_used);
        if (out_last !== want.fin)        note_mismatch("last", want.fin, out_last);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d still expected",
               QUIET_LIMIT, cp_expect_q.size());
      $display("utf8_stream_decoder_top_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input int unsigned sender, input int unsigned receiver);
    idle_pct  = sender;
    stall_pct = receiver;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Lowest and highest single-byte code points
  task automatic test_ascii_extremes();
    str_bytes = '{8'h00, 8'h7F};
    send_text();
  endtask

  // 2-, 3- and 4-byte forms; F7 BF BF BF gives the largest 21-bit value
  task automatic test_multibyte();
    str_bytes = '{8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80};
    send_text();
    str_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_text();
  endtask

  // Leads that start nothing: F8, FF and a lone continuation
  task automatic test_bad_leads();
    str_bytes = '{8'hF8, 8'hFF, 8'h80};
    send_text();
  endtask

  // Bad continuation: flagged early in a 3-byte form, and on the fourth byte
  // of a 4-byte form, where one byte resolves into four words
  task automatic test_bad_continuation();
    str_bytes = '{8'hE2, 8'h41};
    send_text();
    str_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h41};
    send_text();
  endtask

  // Sequence cut short by the end of the string: each held byte rescanned
  task automatic test_cut_short();
    str_bytes = '{8'hF0, 8'h9F, 8'h98};
    send_text();
  endtask

  // Mostly well-formed text with random content; about one string in five has each
  // character broken with odds of 35 percent
  task automatic test_random_text(input int unsigned words);
    int unsigned stop_at;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      build_string(6, ($urandom_range(99) < 20) ? 35 : 0);
      send_text();
    end
  endtask

  // Receiver holds off while the sender keeps offering; the queue fills and
  // in_ready drops, then everything drains in order
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_seq++;
    while (str_bytes.size() < 24) build_string(4, 25);
    send_text();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0, 0);
    test_ascii_extremes();
    test_multibyte();
    test_bad_leads();
    test_bad_continuation();
    test_cut_short();

    set_idling(0, 0);
    test_random_text(PHASE_WORDS);
    set_idling(62, 0);
    test_random_text(PHASE_WORDS);
    set_idling(0, 62);
    test_random_text(PHASE_WORDS);
    set_idling(15, 15);
    test_random_text(PHASE_WORDS);

    test_backpressure();

    in_valid <= 1'b0;
    set_idling(0, 15);
    while (cp_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d strings: extremes, bad leads, bad and missing",
             words_sent, strings_sent);
    $display("continuations, idling phases and a receiver hold-off; %0d words out, %0d invalid",
             results_seen, invalid_seen);
    if (error_count == 0) begin
      $display("utf8_stream_decoder_top_test: done, clean");
    end else begin
      $display("utf8_stream_decoder_top_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/utf8sd_pkg.sv
sv/utf8sd_front.sv
sv/utf8sd_back.sv
sv/utf8_stream_decoder_top.sv
tb/sv/utf8_stream_decoder_top_test.sv
